// ===== src/ptp_pkg.sv =====
// ---------------------------------------------------------------------------
// ptp_pkg
// Shared types, constants and helpers for the point-to-plane accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

   localparam int JAC_W     = 64;   // Jacobian entry and residual width
   localparam int WIDE_W    = 128;  // exact product width
   localparam int NUM_JAC   = 7;    // six Jacobian entries plus the residual
   localparam int NUM_TERMS = 27;   // 21 JTJ + 6 JTr
   localparam int IDX_W     = 5;
   localparam int JIDX_W    = 3;
   localparam int OUT_W     = 64;
   localparam int SHIFT_NC  = 12;
   localparam int SHIFT_CC  = 28;
   localparam int SHIFT_NN  = 4;

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(NUM_TERMS - 1);

   // Row and column of each term; column 6 selects the residual
   localparam logic [JIDX_W-1:0] TERM_ROW [NUM_TERMS] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3,
      3'd4, 3'd4,
      3'd5,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
   localparam logic [JIDX_W-1:0] TERM_COL [NUM_TERMS] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd2, 3'd3, 3'd4, 3'd5,
      3'd3, 3'd4, 3'd5,
      3'd4, 3'd5,
      3'd5,
      3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};

   typedef struct packed {
      logic [NUM_JAC-1:0][JAC_W-1:0] jac;
      logic                          last;
   } jac_type;

   function automatic logic [JAC_W-1:0] sat_to_jac(input logic [WIDE_W-1:0] v);
      logic [JAC_W-1:0] r;
      if ((&v[WIDE_W-1:JAC_W-1]) || !(|v[WIDE_W-1:JAC_W-1]))
         r = v[JAC_W-1:0];
      else if (v[WIDE_W-1])
         r = {1'b1, {(JAC_W-1){1'b0}}};
      else
         r = {1'b0, {(JAC_W-1){1'b1}}};
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/ptp_if.sv =====
// ---------------------------------------------------------------------------
// ptp_req_if / ptp_rsp_if
// Valid/ready channels for correspondences and for emitted sums.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptp_req_if #(
   parameter int COORD_WIDTH  = 32,
   parameter int NORMAL_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  source_x;
   logic signed [COORD_WIDTH-1:0]  source_y;
   logic signed [COORD_WIDTH-1:0]  source_z;
   logic signed [COORD_WIDTH-1:0]  target_x;
   logic signed [COORD_WIDTH-1:0]  target_y;
   logic signed [COORD_WIDTH-1:0]  target_z;
   logic signed [NORMAL_WIDTH-1:0] normal_x;
   logic signed [NORMAL_WIDTH-1:0] normal_y;
   logic signed [NORMAL_WIDTH-1:0] normal_z;
   logic                           last_item;

   modport source (output valid, source_x, source_y, source_z, target_x, target_y,
                   target_z, normal_x, normal_y, normal_z, last_item, input ready);
   modport sink (input valid, source_x, source_y, source_z, target_x, target_y,
                 target_z, normal_x, normal_y, normal_z, last_item, output ready);
endinterface

interface ptp_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         entry_index;
   logic signed [63:0] entry_value;
   logic               last_result;

   modport source (output valid, entry_index, entry_value, last_result, input ready);
   modport sink (input valid, entry_index, entry_value, last_result, output ready);
endinterface

`default_nettype wire

// ===== src/ptp_front.sv =====
// ---------------------------------------------------------------------------
// ptp_front
// Takes a request, forms p x n and the residual with one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module ptp_front
   import ptp_pkg::*;
#(
   parameter int COORD_WIDTH  = 32,
   parameter int NORMAL_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ptp_req_if.sink   req,
   output jac_type   push_data,
   output logic      push_valid,
   input  wire logic queue_full
);
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = DW + NORMAL_WIDTH;
   localparam int SW = PW + 2;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_DRAIN, F_PUSH} state_type;

   state_type                      state_ff;
   logic signed [COORD_WIDTH-1:0]  p_ff [3];
   logic signed [DW-1:0]           d_ff [3];
   logic signed [NORMAL_WIDTH-1:0] n_ff [3];
   logic                           last_ff;
   logic [3:0]                     step_ff;
   logic [3:0]                     pstep_ff;
   logic                           pvalid_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [SW-1:0]           cross_ff [3];
   logic signed [SW-1:0]           res_ff;

   logic signed [DW-1:0]           mul_a;
   logic signed [NORMAL_WIDTH-1:0] mul_b;

   assign req.ready = (state_ff == F_IDLE);

   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = DW'(p_ff[1]); mul_b = n_ff[2]; end
         4'd1:    begin mul_a = DW'(p_ff[2]); mul_b = n_ff[1]; end
         4'd2:    begin mul_a = DW'(p_ff[2]); mul_b = n_ff[0]; end
         4'd3:    begin mul_a = DW'(p_ff[0]); mul_b = n_ff[2]; end
         4'd4:    begin mul_a = DW'(p_ff[0]); mul_b = n_ff[1]; end
         4'd5:    begin mul_a = DW'(p_ff[1]); mul_b = n_ff[0]; end
         4'd6:    begin mul_a = d_ff[0];      mul_b = n_ff[0]; end
         4'd7:    begin mul_a = d_ff[1];      mul_b = n_ff[1]; end
         default: begin mul_a = d_ff[2];      mul_b = n_ff[2]; end
      endcase
   end

   always_comb begin
      push_valid = (state_ff == F_PUSH);
      for (int i = 0; i < 3; i++) begin
         push_data.jac[i]     = JAC_W'(n_ff[i]);
         push_data.jac[3 + i] = sat_to_jac(WIDE_W'(cross_ff[i]));
      end
      push_data.jac[6] = sat_to_jac(WIDE_W'(res_ff));
      push_data.last   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         pvalid_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         pvalid_ff <= (state_ff == F_MUL);
         unique case (state_ff)
            F_IDLE: begin
               if (req.valid) begin
                  p_ff[0]     <= req.source_x;
                  p_ff[1]     <= req.source_y;
                  p_ff[2]     <= req.source_z;
                  d_ff[0]     <= DW'(req.source_x) - DW'(req.target_x);
                  d_ff[1]     <= DW'(req.source_y) - DW'(req.target_y);
                  d_ff[2]     <= DW'(req.source_z) - DW'(req.target_z);
                  n_ff[0]     <= req.normal_x;
                  n_ff[1]     <= req.normal_y;
                  n_ff[2]     <= req.normal_z;
                  last_ff     <= req.last_item;
                  cross_ff[0] <= '0;
                  cross_ff[1] <= '0;
                  cross_ff[2] <= '0;
                  res_ff      <= '0;
                  step_ff     <= '0;
                  state_ff    <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff   <= PW'(mul_a) * PW'(mul_b);
               pstep_ff  <= step_ff;
               if (step_ff == 4'd8)
                  state_ff <= F_DRAIN;
               else
                  step_ff <= step_ff + 4'd1;
            end
            F_DRAIN: state_ff <= F_PUSH;
            F_PUSH:  if (!queue_full) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase

         // accumulate the product issued in the previous cycle
         if (pvalid_ff) begin
            case (pstep_ff)
               4'd0:    cross_ff[0] <= cross_ff[0] + SW'(prod_ff);
               4'd1:    cross_ff[0] <= cross_ff[0] - SW'(prod_ff);
               4'd2:    cross_ff[1] <= cross_ff[1] + SW'(prod_ff);
               4'd3:    cross_ff[1] <= cross_ff[1] - SW'(prod_ff);
               4'd4:    cross_ff[2] <= cross_ff[2] + SW'(prod_ff);
               4'd5:    cross_ff[2] <= cross_ff[2] - SW'(prod_ff);
               default: res_ff      <= res_ff + SW'(prod_ff);
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/ptp_queue.sv =====
// ---------------------------------------------------------------------------
// ptp_queue
// Two-entry queue of Jacobian records between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ptp_queue
   import ptp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire jac_type push_data,
   input  wire logic    push_valid,
   output logic         full,
   output jac_type      pop_data,
   output logic         pop_valid,
   input  wire logic    pop
);
   jac_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ff] <= push_data;
            wr_ff         <= ~wr_ff;
         end
         if (do_pop) rd_ff <= ~rd_ff;
         if (do_push && !do_pop)
            count_ff <= count_ff + 2'd1;
         else if (!do_push && do_pop)
            count_ff <= count_ff - 2'd1;
      end
   end

endmodule

`default_nettype wire

// ===== src/ptp_back.sv =====
// ---------------------------------------------------------------------------
// ptp_back
// Forms each of the 27 products over 32x32 partial products, accumulates
// them with saturation and emits the sums on a marked request.
// ---------------------------------------------------------------------------
`default_nettype none

module ptp_back
   import ptp_pkg::*;
#(
   parameter int ACC_WIDTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire jac_type pop_data,
   input  wire logic    pop_valid,
   output logic         pop,
   ptp_rsp_if.source    rsp
);
   localparam int HW = JAC_W / 2;

   typedef enum logic [2:0] {
      B_IDLE, B_LOAD, B_MUL, B_SIGN, B_SHIFT, B_ACC, B_EMIT
   } state_type;

   state_type               state_ff;
   jac_type                 cur_ff;
   logic [IDX_W-1:0]        k_ff;
   logic [1:0]              step_ff;
   logic [JAC_W-1:0]        ma_ff;
   logic [JAC_W-1:0]        mb_ff;
   logic                    neg_ff;
   logic [WIDE_W-1:0]       prod_ff;
   logic [ACC_WIDTH-1:0]    term_ff;
   logic [ACC_WIDTH-1:0]    acc_ff [NUM_TERMS];
   logic                    valid_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [OUT_W-1:0]        value_ff;
   logic                    lastr_ff;

   logic [JIDX_W-1:0]       row;
   logic [JIDX_W-1:0]       col;
   logic [JAC_W-1:0]        op_a;
   logic [JAC_W-1:0]        op_b;
   logic [HW-1:0]           half_a;
   logic [HW-1:0]           half_b;
   logic [JAC_W-1:0]        partial;
   logic [WIDE_W-1:0]       partial_sh;
   logic signed [WIDE_W-1:0] shifted;
   logic signed [WIDE_W-1:0] acc_sum;

   function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [WIDE_W-1:0] v);
      logic [ACC_WIDTH-1:0] r;
      if ((&v[WIDE_W-1:ACC_WIDTH-1]) || !(|v[WIDE_W-1:ACC_WIDTH-1]))
         r = v[ACC_WIDTH-1:0];
      else if (v[WIDE_W-1])
         r = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      else
         r = {1'b0, {(ACC_WIDTH-1){1'b1}}};
      return r;
   endfunction

   assign row     = TERM_ROW[k_ff];
   assign col     = TERM_COL[k_ff];
   assign op_a    = cur_ff.jac[row];
   assign op_b    = cur_ff.jac[col];
   assign half_a  = step_ff[0] ? ma_ff[JAC_W-1:HW] : ma_ff[HW-1:0];
   assign half_b  = step_ff[1] ? mb_ff[JAC_W-1:HW] : mb_ff[HW-1:0];
   assign partial = JAC_W'(half_a) * JAC_W'(half_b);

   always_comb begin
      case (step_ff)
         2'd0:    partial_sh = WIDE_W'(partial);
         2'd3:    partial_sh = WIDE_W'(partial) << JAC_W;
         default: partial_sh = WIDE_W'(partial) << HW;
      endcase
   end

   // normal*normal is exact; mixed and cross terms round half up
   always_comb begin
      if (row < JIDX_W'(3) && col < JIDX_W'(3))
         shifted = signed'(prod_ff) <<< SHIFT_NN;
      else if (row < JIDX_W'(3) || col < JIDX_W'(3))
         shifted = (signed'(prod_ff) + (WIDE_W'(1) << (SHIFT_NC - 1))) >>> SHIFT_NC;
      else
         shifted = (signed'(prod_ff) + (WIDE_W'(1) << (SHIFT_CC - 1))) >>> SHIFT_CC;
   end

   assign acc_sum = WIDE_W'(signed'(acc_ff[k_ff])) + WIDE_W'(signed'(term_ff));

   assign pop             = (state_ff == B_IDLE);
   assign rsp.valid       = valid_ff;
   assign rsp.entry_index = idx_ff;
   assign rsp.entry_value = value_ff;
   assign rsp.last_result = lastr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         k_ff     <= '0;
         step_ff  <= '0;
         for (int i = 0; i < NUM_TERMS; i++) acc_ff[i] <= '0;
      end else begin
         // a held sum stays; otherwise the emit state loads a fresh one
         valid_ff <= (valid_ff && !rsp.ready) || (state_ff == B_EMIT);
         unique case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  cur_ff   <= pop_data;
                  k_ff     <= '0;
                  state_ff <= B_LOAD;
               end
            end
            B_LOAD: begin
               ma_ff    <= op_a[JAC_W-1] ? -op_a : op_a;
               mb_ff    <= op_b[JAC_W-1] ? -op_b : op_b;
               neg_ff   <= op_a[JAC_W-1] ^ op_b[JAC_W-1];
               prod_ff  <= '0;
               step_ff  <= '0;
               state_ff <= B_MUL;
            end
            B_MUL: begin
               prod_ff <= prod_ff + partial_sh;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) state_ff <= B_SIGN;
            end
            B_SIGN: begin
               if (neg_ff) prod_ff <= -prod_ff;
               state_ff <= B_SHIFT;
            end
            B_SHIFT: begin
               term_ff  <= sat_acc(shifted);
               state_ff <= B_ACC;
            end
            B_ACC: begin
               acc_ff[k_ff] <= sat_acc(acc_sum);
               if (k_ff == LAST_INDEX) begin
                  k_ff     <= '0;
                  state_ff <= cur_ff.last ? B_EMIT : B_IDLE;
               end else begin
                  k_ff     <= k_ff + IDX_W'(1);
                  state_ff <= B_LOAD;
               end
            end
            B_EMIT: begin
               if (!valid_ff || rsp.ready) begin
                  idx_ff       <= k_ff;
                  value_ff     <= OUT_W'(signed'(acc_ff[k_ff]));
                  lastr_ff     <= (k_ff == LAST_INDEX);
                  acc_ff[k_ff] <= '0;
                  if (k_ff == LAST_INDEX)
                     state_ff <= B_IDLE;
                  else
                     k_ff <= k_ff + IDX_W'(1);
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/point_to_plane_normal_equations.sv =====
// The front end forms p x n and the residual and pushes the Jacobian to a two-entry
// queue; the back end forms the 27 sums in turn (load, multiply, sign, shift,
// accumulate) and emits them all on a marked request. The front end takes a new
// request only once its last is pushed. Throughput is set by the back end's
// single 32x32 multiplier (4 partial products per sum); the front end overlaps it.
// Reset (synchronous, active high) clears control state and all 27 sums.
// ---------------------------------------------------------------------------
// point_to_plane_normal_equations
// Accumulates point-to-plane normal equations J^T J and J^T r.
// ---------------------------------------------------------------------------
`default_nettype none

module point_to_plane_normal_equations
   import ptp_pkg::*;
#(
   parameter int COORD_WIDTH  = 32,
   parameter int NORMAL_WIDTH = 16,
   parameter int ACC_WIDTH    = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ptp_req_if.sink   req,
   ptp_rsp_if.source rsp
);
   jac_type push_data;
   logic    push_valid;
   logic    queue_full;
   jac_type pop_data;
   logic    pop_valid;
   logic    pop;

   ptp_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .NORMAL_WIDTH (NORMAL_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_data  (push_data),
      .push_valid (push_valid),
      .queue_full (queue_full)
   );

   ptp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .full       (queue_full),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop        (pop)
   );

   ptp_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== src/ptp_checker.sv =====
// ---------------------------------------------------------------------------
// ptp_checker
// Port-level checks on the emitted sums.
// ---------------------------------------------------------------------------
`default_nettype none

module ptp_checker
   import ptp_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [IDX_W-1:0] rsp_entry_index,
   input wire logic [OUT_W-1:0] rsp_entry_value,
   input wire logic             rsp_last_result
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_index)
                                  && $stable(rsp_entry_value))
      else $error("sum changed while stalled");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_result == (rsp_entry_index == LAST_INDEX)))
      else $error("last flag not on final entry");

   a_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result ##1 rsp_valid
      |-> rsp_entry_index == $past(rsp_entry_index) + IDX_W'(1))
      else $error("entries out of order");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("sum shown after reset");

endmodule

bind point_to_plane_normal_equations ptp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_entry_index (rsp.entry_index),
   .rsp_entry_value (rsp.entry_value),
   .rsp_last_result (rsp.last_result)
);

`default_nettype wire
